>>> rtl/core/rdc_pkg.sv
// Shared types, constants and the reciprocal table for the radix digit conversion unit.
`default_nettype none
package rdc_pkg;

   localparam int VALUE_W  = 32;
   localparam int RESULT_W = 64;
   localparam int DIGIT_W  = 4;
   localparam int RECIP_W  = 35;
   localparam int DIV_SHIFT = 35;
   localparam int PROD_W   = VALUE_W + RECIP_W;

   localparam logic [DIGIT_W-1:0] DEC_BASE  = 4'd10;
   localparam logic [DIGIT_W-1:0] RADIX_MIN = 4'd2;
   localparam logic [DIGIT_W-1:0] RADIX_MAX = 4'd10;

   localparam logic FUNC_TO_BINARY = 1'b0;
   localparam logic FUNC_TO_DIGITS = 1'b1;

   typedef struct packed {
      logic load;
      logic mul_en;
      logic div_en;
      logic mac_en;
   } ctrl_type;

   // ceil(2^35 / d): exact quotient for every dividend up to 2^31
   function automatic logic [RECIP_W-1:0] recip(input logic [DIGIT_W-1:0] d);
      logic [RECIP_W-1:0] r;
      case (d)
         4'd2:    r = 35'd17179869184;
         4'd3:    r = 35'd11453246123;
         4'd4:    r = 35'd8589934592;
         4'd5:    r = 35'd6871947674;
         4'd6:    r = 35'd5726623062;
         4'd7:    r = 35'd4908534053;
         4'd8:    r = 35'd4294967296;
         4'd9:    r = 35'd3817748708;
         default: r = 35'd3435973837;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

>>> rtl/core/rdc_digit_unit.sv
// Digit extraction: reciprocal multiply, then quotient and remainder of a small divisor.
`default_nettype none
module rdc_digit_unit (
   input  wire logic                          clock,
   input  wire rdc_pkg::ctrl_type             ctrl,
   input  wire logic [rdc_pkg::VALUE_W-1:0]   mag_init,
   input  wire logic [rdc_pkg::DIGIT_W-1:0]   src,
   output logic      [rdc_pkg::DIGIT_W-1:0]   digit,
   output logic                               quot_zero
);
   import rdc_pkg::*;

   logic [VALUE_W-1:0] mag_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic [DIGIT_W-1:0] digit_ff;

   logic [VALUE_W-1:0]   quot;
   logic [2*DIGIT_W-1:0] qs_low;
   logic [PROD_W-1:0]    prod_in;

   assign prod_in   = {{RECIP_W{1'b0}}, mag_ff} * {{VALUE_W{1'b0}}, recip(src)};
   assign quot      = prod_ff[PROD_W-1:DIV_SHIFT];
   // remainder is below the divisor, so four low bits are enough
   assign qs_low    = {{DIGIT_W{1'b0}}, quot[DIGIT_W-1:0]} * {{DIGIT_W{1'b0}}, src};
   assign quot_zero = (quot == '0);
   assign digit     = digit_ff;

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         mag_ff <= mag_init;
      end else if (ctrl.div_en) begin
         mag_ff   <= quot;
         digit_ff <= mag_ff[DIGIT_W-1:0] - qs_low[DIGIT_W-1:0];
      end
      if (ctrl.mul_en) begin
         prod_ff <= prod_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/core/rdc_mac_unit.sv
// Weighted digit accumulator with saturation against the signed 64-bit limit.
`default_nettype none
module rdc_mac_unit (
   input  wire logic                          clock,
   input  wire rdc_pkg::ctrl_type             ctrl,
   input  wire logic [rdc_pkg::DIGIT_W-1:0]   digit,
   input  wire logic [rdc_pkg::DIGIT_W-1:0]   dst,
   input  wire logic [rdc_pkg::RESULT_W-1:0]  lim,
   output logic      [rdc_pkg::RESULT_W-1:0]  acc,
   output logic                               ovf
);
   import rdc_pkg::*;

   logic [RESULT_W-1:0] acc_ff;
   logic [RESULT_W-1:0] w_ff;
   logic                w_big_ff;
   logic                ovf_ff;

   logic [RESULT_W+DIGIT_W-1:0]   term;
   logic [RESULT_W+DIGIT_W:0]     sum;
   logic [RESULT_W+DIGIT_W-1:0]   w_next;

   assign term   = {{DIGIT_W{1'b0}}, w_ff} * {{RESULT_W{1'b0}}, digit};
   assign sum    = {{(DIGIT_W+1){1'b0}}, acc_ff} + {1'b0, term};
   assign w_next = {{DIGIT_W{1'b0}}, w_ff} * {{RESULT_W{1'b0}}, dst};
   assign acc    = acc_ff;
   assign ovf    = ovf_ff;

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         acc_ff   <= '0;
         w_ff     <= RESULT_W'(1);
         w_big_ff <= 1'b0;
         ovf_ff   <= 1'b0;
      end else if (ctrl.mac_en) begin
         if (digit != '0) begin
            // weight already past the limit: any nonzero digit overflows
            if (w_big_ff || (sum > {{(DIGIT_W+1){1'b0}}, lim})) begin
               ovf_ff <= 1'b1;
            end else if (!ovf_ff) begin
               acc_ff <= sum[RESULT_W-1:0];
            end
         end
         if (!w_big_ff) begin
            if (w_next > {{DIGIT_W{1'b0}}, lim}) begin
               w_big_ff <= 1'b1;
            end else begin
               w_ff <= w_next[RESULT_W-1:0];
            end
         end
      end
   end

endmodule
`default_nettype wire

>>> rtl/core/radix_digit_conversion_unit.sv
// Top level: sequencer driving the digit unit and the accumulator.
//
//  port group | direction | handshake            | payload
//  req_       | in        | start, busy          | req_func, req_value, req_radix
//  rsp_       | out       | rsp_valid (strobe)   | rsp_result, rsp_overflow
//
// After acceptance a request runs S_MUL and S_DIV once per source digit (1 to 32
// digits) on the shared multiplier, then S_FIN and S_DONE, then the result strobe.
// The result strobe lasts one cycle, and busy drops in that same cycle.
// Synchronous reset returns the sequencer to idle and drops any pending result.
// The receiver cannot stall: results are never held back.
`default_nettype none
module radix_digit_conversion_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic                          req_func,
   input  wire logic signed [rdc_pkg::VALUE_W-1:0] req_value,
   input  wire logic [rdc_pkg::DIGIT_W-1:0]   req_radix,
   output logic                               rsp_valid,
   output logic signed [rdc_pkg::RESULT_W-1:0] rsp_result,
   output logic                               rsp_overflow
);
   import rdc_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_DIV,
      S_FIN,
      S_DONE
   } state_type;

   state_type           state_ff;
   logic                have_ff;
   logic                func_ff;
   logic                neg_ff;
   logic [DIGIT_W-1:0]  radix_ff;
   logic                rsp_valid_ff;
   logic [RESULT_W-1:0] rsp_result_ff;
   logic                rsp_overflow_ff;

   ctrl_type            ctrl;
   logic [DIGIT_W-1:0]  radix_in;
   logic [VALUE_W-1:0]  mag_init;
   logic [DIGIT_W-1:0]  src;
   logic [DIGIT_W-1:0]  dst;
   logic [RESULT_W-1:0] lim;
   logic [DIGIT_W-1:0]  digit;
   logic                quot_zero;
   logic [RESULT_W-1:0] acc;
   logic                ovf;
   logic [RESULT_W-1:0] mag_out;

   assign radix_in = (req_radix < RADIX_MIN) ? RADIX_MIN :
                     (req_radix > RADIX_MAX) ? RADIX_MAX : req_radix;
   // two's complement negate also gives 2^31 for the most negative value
   assign mag_init = req_value[VALUE_W-1] ? (~req_value + VALUE_W'(1)) : req_value;

   assign src = (func_ff == FUNC_TO_DIGITS) ? radix_ff : DEC_BASE;
   assign dst = (func_ff == FUNC_TO_DIGITS) ? DEC_BASE : radix_ff;
   assign lim = {1'b0, {(RESULT_W-1){1'b1}}} + RESULT_W'(neg_ff);

   always_comb begin
      ctrl.load   = (state_ff == S_IDLE) && start;
      ctrl.mul_en = (state_ff == S_MUL);
      ctrl.div_en = (state_ff == S_DIV);
      ctrl.mac_en = ((state_ff == S_MUL) && have_ff) || (state_ff == S_FIN);
   end

   rdc_digit_unit u_digit (
      .clock     (clock),
      .ctrl      (ctrl),
      .mag_init  (mag_init),
      .src       (src),
      .digit     (digit),
      .quot_zero (quot_zero)
   );

   rdc_mac_unit u_mac (
      .clock (clock),
      .ctrl  (ctrl),
      .digit (digit),
      .dst   (dst),
      .lim   (lim),
      .acc   (acc),
      .ovf   (ovf)
   );

   assign mag_out = ovf ? lim : acc;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         have_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  func_ff  <= req_func;
                  neg_ff   <= req_value[VALUE_W-1];
                  radix_ff <= radix_in;
                  have_ff  <= 1'b0;
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               state_ff <= S_DIV;
            end
            S_DIV: begin
               have_ff  <= 1'b1;
               state_ff <= quot_zero ? S_FIN : S_MUL;
            end
            S_FIN: begin
               state_ff <= S_DONE;
            end
            S_DONE: begin
               rsp_result_ff   <= neg_ff ? (~mag_out + RESULT_W'(1)) : mag_out;
               rsp_overflow_ff <= ovf;
               rsp_valid_ff    <= 1'b1;
               state_ff        <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy         = (state_ff != S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_result   = rsp_result_ff;
   assign rsp_overflow = rsp_overflow_ff;

endmodule
`default_nettype wire

>>> rtl/core/rdc_checker.sv
// Port-level checks for the radix digit conversion unit, bound to the top level.
`default_nettype none
module rdc_checker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic                          busy,
   input  wire logic                          rsp_valid,
   input  wire logic [rdc_pkg::RESULT_W-1:0]  rsp_result,
   input  wire logic                          rsp_overflow
);
   import rdc_pkg::*;

   // an accepted request keeps the unit busy
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted but unit not busy");

   // the result strobe lasts a single cycle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while busy");

   // busy ends only with a result
   assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> rsp_valid)
      else $error("busy dropped without a result");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_overflow) |->
         ((rsp_result == {1'b0, {(RESULT_W-1){1'b1}}}) ||
          (rsp_result == {1'b1, {(RESULT_W-1){1'b0}}})))
      else $error("overflow without saturated result");

endmodule

bind radix_digit_conversion_unit rdc_checker u_rdc_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .rsp_valid    (rsp_valid),
   .rsp_result   (rsp_result),
   .rsp_overflow (rsp_overflow)
);
`default_nettype wire
